// ===== rtl/core/sgnms_pkg.sv =====
// ----------------------------------------------------------------------------
// sgnms_pkg
// Shared constants, types and codes of the Sobel gradient and edge thinning
// block.
// ----------------------------------------------------------------------------
package sgnms_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;
    localparam int MIN_SIZE      = 3;

    localparam int PIX_W     = 8;
    localparam int HEIGHT_W  = 12;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // quantized gradient direction
    localparam logic [1:0] DIR_0   = 2'd0;
    localparam logic [1:0] DIR_45  = 2'd1;
    localparam logic [1:0] DIR_90  = 2'd2;
    localparam logic [1:0] DIR_135 = 2'd3;

    localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

    // position flags worked out by the front end for one item
    typedef struct packed {
        logic g_first;      // gradient target in first column
        logic g_last;       // gradient target in last column
        logic g_top;        // gradient target in first row
        logic g_bottom;     // gradient target in last row
        logic s_first;      // edge target in first column
        logic s_last;       // edge target in last column
        logic s_top;        // edge target in first row
        logic s_bottom;     // edge target in last row
        logic emit;         // item produces a result
        logic row_end;
        logic frame_end;
    } job_flags_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GRAD,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_DONE
    } back_state_t;

endpackage

// ===== rtl/core/sgnms_ram.sv =====
// ----------------------------------------------------------------------------
// sgnms_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sgnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/sgnms_queue.sv =====
// ----------------------------------------------------------------------------
// sgnms_queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sgnms_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/core/sgnms_front.sv =====
// ----------------------------------------------------------------------------
// sgnms_front
// Accepts items and register writes, tracks the frame position and tags
// each item with its border and output flags.
// ----------------------------------------------------------------------------
module sgnms_front #(
    parameter int MAX_WIDTH = sgnms_pkg::MAX_WIDTH_DEF,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int WW = $clog2(MAX_WIDTH + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               mode,
    input  logic [sgnms_pkg::PIX_W-1:0]        pixel,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sgnms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sgnms_pkg::CFG_W-1:0]        cfg_data,
    input  logic                               q_full,
    output logic                               q_push,
    output sgnms_pkg::job_flags_t              job_flags,
    output logic [sgnms_pkg::PIX_W-1:0]        job_pix,
    output logic [CW-1:0]                      job_col,
    output logic [CW-1:0]                      job_gcol
);

    import sgnms_pkg::*;

    localparam int FW    = WW + 2;
    localparam int W_RST = (WIDTH_RESET < MAX_WIDTH) ? WIDTH_RESET : MAX_WIDTH;

    logic [WW-1:0]       width_reg, width_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic [FW-1:0]       fill_reg, fill_next;

    logic                accept;
    logic                cfg_wr;
    logic                c_zero, c_one, c_two;
    logic                last_col, last_row;
    logic [FW-1:0]       fill_target;
    logic [12:0]         wv;
    logic [HEIGHT_W-1:0] hv;

    // a register write takes the cycle, no item is taken beside it
    assign in_ready  = !q_full && !cfg_valid;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign q_push    = accept;
    assign cfg_wr    = cfg_valid;

    assign c_zero   = (col_reg == CW'(0));
    assign c_one    = (col_reg == CW'(1));
    assign c_two    = (col_reg == CW'(2));
    assign last_col = (WW'(col_reg) == width_reg - WW'(1));
    assign last_row = (row_reg == height_reg - HEIGHT_W'(1));

    assign fill_target = (FW'(width_reg) << 1) + FW'(2);

    // gradient target sits w+1 slots back, edge target 2w+2 slots back
    always_comb
    begin
        job_flags.g_first   = c_one;
        job_flags.g_last    = c_zero;
        job_flags.g_top     = (row_reg == (c_zero ? 12'd2 : 12'd1));
        job_flags.g_bottom  = (row_reg == (c_zero ? 12'd1 : 12'd0));
        job_flags.s_first   = c_two;
        job_flags.s_last    = c_one;
        // three rows back wraps onto row 0 itself in a three-row frame
        job_flags.s_top     = (c_zero || c_one) ?
                              ((row_reg == 12'd3) ||
                               (row_reg == 12'd0 && height_reg == 12'd3)) :
                              (row_reg == 12'd2);
        job_flags.s_bottom  = (row_reg == ((c_zero || c_one) ? 12'd2 : 12'd1));
        job_flags.emit      = (fill_reg == fill_target);
        job_flags.row_end   = c_one;
        job_flags.frame_end = c_one && (row_reg == 12'd2);
        job_pix             = mode ? '0 : pixel;
        job_col             = col_reg;
        job_gcol            = c_zero ? CW'(width_reg - WW'(1)) : col_reg - CW'(1);
    end

    always_comb
    begin
        wv = 13'(cfg_data[10:0]);
        hv = cfg_data[HEIGHT_W-1:0];
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        fill_next   = fill_reg;
        if (cfg_wr && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT))
        begin
            if (cfg_index == REG_FRAME_WIDTH)
            begin
                if (wv < 13'(MIN_SIZE))
                begin
                    width_next = WW'(MIN_SIZE);
                end
                else if (wv > 13'(MAX_WIDTH))
                begin
                    width_next = WW'(MAX_WIDTH);
                end
                else
                begin
                    width_next = WW'(wv);
                end
            end
            else
            begin
                height_next = (hv < HEIGHT_W'(MIN_SIZE)) ? HEIGHT_W'(MIN_SIZE) : hv;
            end
            col_next  = '0;
            row_next  = '0;
            fill_next = '0;
        end
        else if (accept)
        begin
            if (fill_reg != fill_target)
            begin
                fill_next = fill_reg + FW'(1);
            end
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + HEIGHT_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WW'(W_RST);
            height_reg <= HEIGHT_W'(HEIGHT_RESET);
            col_reg    <= '0;
            row_reg    <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== rtl/core/sgnms_back.sv =====
// ----------------------------------------------------------------------------
// sgnms_back
// Line buffers, Sobel gradient, magnitude and direction, and edge thinning
// of one item over a short sequence of steps.
// ----------------------------------------------------------------------------
module sgnms_back #(
    parameter int MAX_WIDTH = sgnms_pkg::MAX_WIDTH_DEF,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    output logic                           q_pop,
    input  sgnms_pkg::job_flags_t          q_flags,
    input  logic [sgnms_pkg::PIX_W-1:0]    q_pix,
    input  logic [CW-1:0]                  q_col,
    input  logic [CW-1:0]                  q_gcol,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sgnms_pkg::PIX_W-1:0]    edge_value,
    output logic                           row_end,
    output logic                           frame_end
);

    import sgnms_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } triple_t;

    function automatic triple_t fold_rows(triple_t t, logic first, logic last);
        triple_t o;
        o = t;
        if (first)
        begin
            o.top = t.bot;
        end
        if (last)
        begin
            o.bot = t.top;
        end
        return o;
    endfunction

    function automatic logic [10:0] wsum(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                         logic [PIX_W-1:0] c);
        return 11'(a) + {2'b00, b, 1'b0} + 11'(c);
    endfunction

    back_state_t state_reg, state_next;

    job_flags_t       flags_reg;
    logic [PIX_W-1:0] pix_reg;
    logic [CW-1:0]    col_reg, gcol_reg;

    triple_t p1_reg, p2_reg, m1_reg, m2_reg;
    logic [1:0] d1_reg;

    logic signed [10:0] gx_reg, gy_reg, gx_next, gy_next;
    logic [19:0] ax2_reg, gy2_reg, sd2_reg;
    logic [21:0] sp2_reg;
    logic        gy_zero_reg, gx_pos_reg, gx_zero_reg, gy_le_ax_reg;
    logic [15:0] v_reg;
    logic        sat_reg;
    logic [1:0]  dir_reg, dir_next;
    logic [7:0]  root_reg, bit_reg;

    logic             out_valid_reg;
    logic [PIX_W-1:0] edge_reg;
    logic             row_end_reg, frame_end_reg;

    logic [PIX_W-1:0] plb0_q, plb1_q, mlb0_q, mlb1_q;
    logic [1:0]       dlb_q;

    logic pix_we, mag_we, advance, load;

    // datapath temporaries
    triple_t            pin, wl, wm, wr, min;
    logic [10:0]        sl, sr, st, sb;
    logic signed [10:0] gxf, gyf_s;
    logic [9:0]         gyf, ax, sd;
    logic [10:0]        sp;
    logic [20:0]        vsum;
    logic               lo, hi;
    logic [7:0]         trial;
    logic [15:0]        trial_sq;
    logic [PIX_W-1:0]   mag, na, nb, mx;
    logic               va, vb;

    // line buffers: pixels of the two rows above, magnitudes of the two
    // rows above, directions of the row above
    sgnms_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_plb0 (
        .clk(clk), .we(pix_we), .waddr(col_reg), .wdata(pix_reg),
        .re(q_pop), .raddr(q_col), .rdata(plb0_q)
    );

    sgnms_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_plb1 (
        .clk(clk), .we(pix_we), .waddr(col_reg), .wdata(plb0_q),
        .re(q_pop), .raddr(q_col), .rdata(plb1_q)
    );

    sgnms_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mlb0 (
        .clk(clk), .we(mag_we), .waddr(gcol_reg), .wdata(mag),
        .re(q_pop), .raddr(q_gcol), .rdata(mlb0_q)
    );

    sgnms_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mlb1 (
        .clk(clk), .we(mag_we), .waddr(gcol_reg), .wdata(mlb0_q),
        .re(q_pop), .raddr(q_gcol), .rdata(mlb1_q)
    );

    sgnms_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_dlb (
        .clk(clk), .we(mag_we), .waddr(gcol_reg), .wdata(dir_reg),
        .re(q_pop), .raddr(q_gcol), .rdata(dlb_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   state_next = q_empty ? ST_IDLE : ST_GRAD;
            ST_GRAD:   state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_SUM;
            ST_SUM:    state_next = ST_ROOT;
            ST_ROOT:   state_next = bit_reg[0] ? ST_DONE : ST_ROOT;
            ST_DONE:   state_next = advance ? ST_IDLE : ST_DONE;
        endcase
    end

    // state outputs
    always_comb
    begin
        q_pop   = 1'b0;
        pix_we  = 1'b0;
        advance = 1'b0;
        unique case (state_reg)
            ST_IDLE: q_pop  = !q_empty;
            ST_GRAD: pix_we = 1'b1;
            ST_DONE: advance = !flags_reg.emit || !out_valid_reg || out_ready;
            ST_SQUARE, ST_SUM, ST_ROOT: ;
        endcase
        mag_we = advance;
        load   = advance && flags_reg.emit;
    end

    // sobel window with reflected borders
    always_comb
    begin
        pin = {plb1_q, plb0_q, pix_reg};
        wl  = fold_rows(flags_reg.g_first ? pin : p2_reg, flags_reg.g_top, flags_reg.g_bottom);
        wm  = fold_rows(p1_reg, flags_reg.g_top, flags_reg.g_bottom);
        wr  = fold_rows(flags_reg.g_last ? p2_reg : pin, flags_reg.g_top, flags_reg.g_bottom);
        sl  = wsum(wl.top, wl.mid, wl.bot);
        sr  = wsum(wr.top, wr.mid, wr.bot);
        st  = wsum(wl.top, wm.top, wr.top);
        sb  = wsum(wl.bot, wm.bot, wr.bot);
        gx_next = 11'($signed({1'b0, sr}) - $signed({1'b0, sl}));
        gy_next = 11'($signed({1'b0, sb}) - $signed({1'b0, st}));
    end

    // fold the angle into the upper half plane
    always_comb
    begin
        gyf_s = (gy_reg < 0) ? -gy_reg : gy_reg;
        gxf   = (gy_reg < 0) ? -gx_reg : gx_reg;
        gyf   = 10'(gyf_s);
        ax    = (gxf < 0) ? 10'(-gxf) : 10'(gxf);
        sp    = 11'(gyf) + 11'(ax);
        sd    = (gyf >= ax) ? gyf - ax : ax - gyf;
    end

    // tangent tests against 22.5 and 67.5 degrees
    always_comb
    begin
        vsum = 21'(ax2_reg) + 21'(gy2_reg);
        lo   = sp2_reg < {1'b0, ax2_reg, 1'b0};
        hi   = gy_le_ax_reg || ({1'b0, sd2_reg} < {ax2_reg, 1'b0});
        if (gy_zero_reg)
        begin
            dir_next = DIR_0;
        end
        else if (gx_pos_reg)
        begin
            dir_next = lo ? DIR_0 : (hi ? DIR_45 : DIR_90);
        end
        else if (gx_zero_reg)
        begin
            dir_next = DIR_90;
        end
        else
        begin
            dir_next = lo ? DIR_0 : (hi ? DIR_135 : DIR_90);
        end
    end

    assign trial    = root_reg | bit_reg;
    assign trial_sq = 16'(trial) * 16'(trial);
    assign mag      = sat_reg ? MAG_MAX : root_reg;

    // neighbours along the gradient direction, outside ones dropped
    always_comb
    begin
        min = {mlb1_q, mlb0_q, mag};
        na  = '0;
        nb  = '0;
        va  = 1'b0;
        vb  = 1'b0;
        unique case (d1_reg)
            DIR_0:
            begin
                na = m2_reg.mid;
                va = !flags_reg.s_first;
                nb = min.mid;
                vb = !flags_reg.s_last;
            end
            DIR_45:
            begin
                na = m2_reg.bot;
                va = !flags_reg.s_first && !flags_reg.s_bottom;
                nb = min.top;
                vb = !flags_reg.s_last && !flags_reg.s_top;
            end
            DIR_90:
            begin
                na = m1_reg.top;
                va = !flags_reg.s_top;
                nb = m1_reg.bot;
                vb = !flags_reg.s_bottom;
            end
            DIR_135:
            begin
                na = min.bot;
                va = !flags_reg.s_last && !flags_reg.s_bottom;
                nb = m2_reg.top;
                vb = !flags_reg.s_first && !flags_reg.s_top;
            end
        endcase
        mx = '0;
        if (va && na > mx)
        begin
            mx = na;
        end
        if (vb && nb > mx)
        begin
            mx = nb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            flags_reg <= q_flags;
            pix_reg   <= q_pix;
            col_reg   <= q_col;
            gcol_reg  <= q_gcol;
        end
        if (state_reg == ST_GRAD)
        begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
            p2_reg <= p1_reg;
            p1_reg <= pin;
        end
        if (state_reg == ST_SQUARE)
        begin
            ax2_reg      <= ax * ax;
            gy2_reg      <= gyf * gyf;
            sp2_reg      <= sp * sp;
            sd2_reg      <= sd * sd;
            gy_zero_reg  <= (gy_reg == 0);
            gx_pos_reg   <= (gxf > 0);
            gx_zero_reg  <= (gxf == 0);
            gy_le_ax_reg <= (gyf <= ax);
        end
        if (state_reg == ST_SUM)
        begin
            v_reg    <= vsum[15:0];
            sat_reg  <= (vsum[20:16] != 5'd0);
            dir_reg  <= dir_next;
            root_reg <= '0;
            bit_reg  <= 8'h80;
        end
        if (state_reg == ST_ROOT)
        begin
            if (trial_sq <= v_reg)
            begin
                root_reg <= trial;
            end
            bit_reg <= bit_reg >> 1;
        end
        if (advance)
        begin
            m2_reg <= m1_reg;
            m1_reg <= min;
            d1_reg <= dlb_q;
        end
        if (load)
        begin
            edge_reg      <= (m1_reg.mid < mx) ? '0 : m1_reg.mid;
            row_end_reg   <= flags_reg.row_end;
            frame_end_reg <= flags_reg.frame_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign edge_value = edge_reg;
    assign row_end    = row_end_reg;
    assign frame_end  = frame_end_reg;

endmodule

// ===== rtl/core/sobel_gradient_nonmax_suppression_top.sv =====
// ----------------------------------------------------------------------------
// sobel_gradient_nonmax_suppression_top
// Streaming Sobel gradient, magnitude, quantized direction and edge thinning
// on a smoothed 8-bit raster, one pixel per item.
// ----------------------------------------------------------------------------
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  in       | in_valid in_ready mode pixel         | sink
//  out      | out_valid out_ready edge_value       | source
//           | row_end frame_end                    |
//  cfg      | cfg_valid cfg_ready cfg_index        | sink
//           | cfg_data                             |
//
// An item passes through 5 steps in the back end: line buffer read,
// gradient, squares, sums and output, plus an 8-bit bit-serial square root.
// The front end takes items into a two-entry queue while the back end works;
// a register write holds off input items for its cycle.
// Reset clears counters and control; line buffers are not cleared, and the
// first result follows 2*frame_width+2 items after reset or a register write.
// A stalled result holds the back end in its last step; the queue keeps
// accepting until full.
// ----------------------------------------------------------------------------
module sobel_gradient_nonmax_suppression_top #(
    parameter int MAX_WIDTH = sgnms_pkg::MAX_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               mode,
    input  logic [sgnms_pkg::PIX_W-1:0]        pixel,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [sgnms_pkg::PIX_W-1:0]        edge_value,
    output logic                               row_end,
    output logic                               frame_end,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sgnms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sgnms_pkg::CFG_W-1:0]        cfg_data
);

    import sgnms_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int QW = $bits(job_flags_t) + PIX_W + 2 * CW;

    job_flags_t       f_flags, b_flags;
    logic [PIX_W-1:0] f_pix, b_pix;
    logic [CW-1:0]    f_col, f_gcol, b_col, b_gcol;
    logic             q_push, q_pop, q_full, q_empty;
    logic [QW-1:0]    q_wdata, q_rdata;

    sgnms_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .pixel     (pixel),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .job_flags (f_flags),
        .job_pix   (f_pix),
        .job_col   (f_col),
        .job_gcol  (f_gcol)
    );

    assign q_wdata = {f_flags, f_pix, f_col, f_gcol};

    sgnms_queue #(.WIDTH(QW)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    assign {b_flags, b_pix, b_col, b_gcol} = q_rdata;

    sgnms_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_flags    (b_flags),
        .q_pix      (b_pix),
        .q_col      (b_col),
        .q_gcol     (b_gcol),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .edge_value (edge_value),
        .row_end    (row_end),
        .frame_end  (frame_end)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("item queued while queue full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("item taken from empty queue");

    a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_end) |-> row_end)
        else $error("frame end without row end");

endmodule
